/* rtl/sqi_pkg.sv */
// Package for the sine quadrature integrator: widths, fixed-point constants,
// the CORDIC arctangent table, state and code types, and the control structs.
// Depends on nothing; every other file of the block imports it.
package sqi_pkg;

    // Payload widths.
    localparam int BOUND_W = 32;
    localparam int PART_W  = 16;
    localparam int RES_W   = 34;
    localparam int METH_W  = 2;

    // Bounds are Q.28, abscissas and angles are Q.40 in a 48-bit word.
    localparam int BOUND_FRAC = 28;
    localparam int ANG_FRAC   = 40;
    localparam int ANG_W      = 48;
    localparam int ANG_PAD    = ANG_FRAC - BOUND_FRAC;
    localparam int ANG_EXT    = ANG_W - BOUND_W - ANG_PAD;

    localparam int MAX_PARTITIONS = 65535;
    localparam int CORDIC_STEPS   = 30;
    localparam int STEP_W         = $clog2(CORDIC_STEPS);

    // Sine in Q.32, up to one in magnitude, so it needs 34 signed bits.
    localparam int SIN_W  = 34;
    localparam int SIN_SH = ANG_FRAC - 32;
    // Weighted sum of up to six sines per subinterval over 65535 subintervals.
    localparam int ACC_W  = 53;

    // Magnitude product |S| * |h| in four partial products.
    localparam int SMAG_W = 52;
    localparam int HMAG_W = 45;
    localparam int PA_W   = 26;
    localparam int PB_W   = 23;
    localparam int PROD_W = PA_W + PB_W;
    localparam int MUL_W  = 97;
    localparam int MAG_LSB = 36;
    localparam int MAG_W  = MUL_W - MAG_LSB;

    // Restoring divider for the step h = (b - a) / n.
    localparam int DIV_W     = 60;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Division by three of the rounded magnitude, 18 bits a cycle by a
    // reciprocal multiply: floor(v / 3) = (v * 699051) >> 21 for v < 2^21.
    localparam int D3_CHUNK = 18;
    localparam int D3_STEPS = 3;
    localparam int D3_W     = D3_CHUNK * D3_STEPS;
    localparam int D3_V_W   = D3_CHUNK + 2;
    localparam int D3_SH    = 21;
    localparam int D3_P_W   = D3_V_W + D3_SH;
    localparam int D3_MUL   = 699051;

    localparam logic signed [ANG_W-1:0] PI_Q40      = 48'sh0000_3243F6A8886;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q40 = 48'sh0000_1921FB54443;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q40  = 48'sh0000_6487ED5110B;
    localparam logic signed [ANG_W-1:0] GAIN_Q40    = 48'sd667681663043;

    // atan(2^-i) in Q.40.
    localparam logic signed [ANG_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        48'sh00C90FDAA222,
        48'sd509785937287,
        48'sd269356888665,
        48'sd136729762476,
        48'sd68630207382,
        48'sd34348560106,
        48'sd17178471287,
        48'sd8589759836,
        48'sd4294945451,
        48'sd2147480917,
        48'sd1073741483,
        48'sd536870869,
        48'sd268435451,
        48'sd134217727,
        48'sd67108864,
        48'sd33554432,
        48'sd16777216,
        48'sd8388608,
        48'sd4194304,
        48'sd2097152,
        48'sd1048576,
        48'sd524288,
        48'sd262144,
        48'sd131072,
        48'sd65536,
        48'sd32768,
        48'sd16384,
        48'sd8192,
        48'sd4096,
        48'sd2048
    };

    // Method register codes.
    localparam logic [METH_W-1:0] METH_RECT = 2'd0;
    localparam logic [METH_W-1:0] METH_TRAP = 2'd1;
    localparam logic [METH_W-1:0] METH_SIMP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_H,
        ST_SIN_GO,
        ST_SIN_WAIT,
        ST_MUL,
        ST_RND,
        ST_RND_WAIT,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_REDUCE,
        CS_ROTATE
    } cordic_state_t;

    // Which abscissa the next sine is taken at.
    typedef enum logic [2:0] {
        PH_A,
        PH_B,
        PH_X,
        PH_MID,
        PH_END
    } phase_t;

    typedef struct packed {
        logic       load;
        logic       set_zero;
        logic       set_bad;
        logic       div_start;
        logic       rnd_start;
        logic       h_take;
        logic       sin_start;
        phase_t     angle_sel;
        logic       sin_add;
        logic [1:0] weight;
        logic       x_step;
        logic       mul_prep;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       mul_acc;
        logic       res_take;
        logic       out_load;
    } sqi_cmd_t;

    typedef struct packed {
        logic              n_zero;
        logic              k_last;
        logic              div_done;
        logic              sin_done;
        logic              rnd_done;
        logic [METH_W-1:0] method;
    } sqi_status_t;

endpackage

/* rtl/sqi_ifs.sv */
// Valid/ready channel interfaces for the integrator's input and result words.
// Depends on sqi_pkg for the payload widths.
interface sqi_in_if
    import sqi_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [BOUND_W-1:0]   lower_bound;
    logic signed [BOUND_W-1:0]   upper_bound;
    logic        [PART_W-1:0]    partitions;

    modport source (output valid, output lower_bound, output upper_bound,
                    output partitions, input ready);
    modport sink   (input valid, input lower_bound, input upper_bound,
                    input partitions, output ready);
endinterface

interface sqi_out_if
    import sqi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [RES_W-1:0]   integral;
    logic                      bad_count;

    modport source (output valid, output integral, output bad_count, input ready);
    modport sink   (input valid, input integral, input bad_count, output ready);
endinterface

/* rtl/sine_quadrature_integrator.sv */
// Definite integral of sin over [a, b] by rectangle, trapezoid or Simpson rule.
// It takes n sines for the rectangle, n + 1 for the trapezoid and 3n for Simpson,
// one after another on the one shared CORDIC unit, which sets the pace; the step
// division comes before the first sine.
// One word at a time; a new word is taken while the previous result still waits.
// Reset clears the control state and sets the method register to left rectangle.
module sine_quadrature_integrator
    import sqi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [METH_W-1:0] cfg_data,
    sqi_in_if.sink            in_ch,
    sqi_out_if.source         out_ch
);

    sqi_cmd_t    cmd;
    sqi_status_t st;

    sqi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    sqi_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .lower_bound (in_ch.lower_bound),
        .upper_bound (in_ch.upper_bound),
        .partitions  (in_ch.partitions),
        .cmd         (cmd),
        .st          (st),
        .integral    (out_ch.integral),
        .bad_count   (out_ch.bad_count)
    );

endmodule

/* rtl/sqi_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sqi_pkg for its widths.
module sqi_div
    import sqi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [PART_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PART_W-1:0]    rem_reg, rem_next;
    logic [PART_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [PART_W:0]      rem_sh;
    logic                 fits;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[DIV_W-1]};
        fits      = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dvd_next  = dvd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            rem_next  = '0;
            dvs_next  = divisor;
            dvd_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? PART_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[PART_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dvd_reg <= dvd_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* rtl/sqi_cordic.sv */
// Rotation-mode CORDIC sine: range reduction by whole turns, folding into
// [-pi/2, pi/2], then one rotation per cycle. Depends on sqi_pkg.
module sqi_cordic
    import sqi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ANG_W-1:0] angle,
    output logic                    done,
    output logic signed [SIN_W-1:0] sine
);

    cordic_state_t           state_reg, state_next;
    logic                    done_reg, done_next;
    logic [STEP_W-1:0]       i_reg, i_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic signed [ANG_W-1:0] x_reg, x_next;
    logic signed [ANG_W-1:0] y_reg, y_next;
    logic signed [SIN_W-1:0] sine_reg, sine_next;
    logic signed [ANG_W-1:0] dx, dy, z_fold, y_rot, y_rnd;

    always_comb
    begin
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        if (z_reg > HALF_PI_Q40)
            z_fold = PI_Q40 - z_reg;
        else if (z_reg < -HALF_PI_Q40)
            z_fold = -PI_Q40 - z_reg;
        else
            z_fold = z_reg;
        y_rot = (z_reg >= 0) ? y_reg + dy : y_reg - dy;
        y_rnd = (y_rot + ANG_W'(128)) >>> SIN_SH;

        state_next = state_reg;
        done_next  = 1'b0;
        i_next     = i_reg;
        z_next     = z_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sine_next  = sine_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    z_next     = angle;
                    state_next = CS_REDUCE;
                end
            end
            CS_REDUCE:
            begin
                if (z_reg > PI_Q40)
                    z_next = z_reg - TWO_PI_Q40;
                else if (z_reg < -PI_Q40)
                    z_next = z_reg + TWO_PI_Q40;
                else
                begin
                    z_next     = z_fold;
                    x_next     = GAIN_Q40;
                    y_next     = '0;
                    i_next     = '0;
                    state_next = CS_ROTATE;
                end
            end
            CS_ROTATE:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - dx;
                    z_next = z_reg - ATAN_TAB[i_reg];
                end
                else
                begin
                    x_next = x_reg + dx;
                    z_next = z_reg + ATAN_TAB[i_reg];
                end
                y_next = y_rot;
                i_next = i_reg + 1'b1;
                if (i_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    sine_next  = y_rnd[SIN_W-1:0];
                    done_next  = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        z_reg    <= z_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        sine_reg <= sine_next;
    end

    assign done = done_reg;
    assign sine = sine_reg;

endmodule

/* rtl/sqi_ctrl.sv */
// Controller of the integrator: sequences the step division, the sine calls
// of each rule, the final product, rounding and the result word.
// Depends on sqi_pkg for the state, phase and command types.
module sqi_ctrl
    import sqi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  sqi_status_t st,
    output sqi_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.angle_sel = phase_reg;
        in_ready   = 1'b0;
        out_free   = !out_valid_reg || out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (st.n_zero)
                begin
                    cmd.set_zero = 1'b1;
                    cmd.set_bad  = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (!(st.method inside {METH_RECT, METH_TRAP, METH_SIMP}))
                begin
                    cmd.set_zero = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_H;
                end
            end
            ST_DIV_H:
            begin
                if (st.div_done)
                begin
                    cmd.h_take = 1'b1;
                    phase_next = (st.method == METH_TRAP) ? PH_A : PH_X;
                    state_next = ST_SIN_GO;
                end
            end
            ST_SIN_GO:
            begin
                cmd.sin_start = 1'b1;
                state_next    = ST_SIN_WAIT;
            end
            ST_SIN_WAIT:
            begin
                if (st.sin_done)
                begin
                    cmd.sin_add = 1'b1;
                    if (phase_reg == PH_MID)
                        cmd.weight = 2'd2;
                    else if (phase_reg == PH_X && st.method == METH_TRAP)
                        cmd.weight = 2'd1;
                    else
                        cmd.weight = 2'd0;

                    if (phase_reg == PH_A)
                    begin
                        phase_next = PH_B;
                        state_next = ST_SIN_GO;
                    end
                    else if (phase_reg == PH_X && st.method == METH_SIMP)
                    begin
                        phase_next = PH_MID;
                        state_next = ST_SIN_GO;
                    end
                    else if (phase_reg == PH_MID)
                    begin
                        phase_next = PH_END;
                        state_next = ST_SIN_GO;
                    end
                    else
                    begin
                        // End of one subinterval, or of the two end points for the trapezoid: advance the abscissa.
                        cmd.x_step = 1'b1;
                        phase_next = PH_X;
                        if (st.k_last)
                        begin
                            cnt_next   = '0;
                            state_next = ST_MUL;
                        end
                        else
                            state_next = ST_SIN_GO;
                    end
                end
            end
            ST_MUL:
            begin
                // Capture magnitudes, then four partial products, each
                // added in the cycle after it is formed.
                cmd.mul_prep = (cnt_reg == 3'd0);
                cmd.mul_en   = (cnt_reg >= 3'd1) && (cnt_reg <= 3'd4);
                cmd.mul_idx  = 2'(cnt_reg - 3'd1);
                cmd.mul_acc  = (cnt_reg >= 3'd2);
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                    state_next = ST_RND;
            end
            ST_RND:
            begin
                cmd.rnd_start = 1'b1;
                state_next    = ST_RND_WAIT;
            end
            ST_RND_WAIT:
            begin
                if (st.rnd_done)
                begin
                    cmd.res_take = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_X;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/sqi_datapath.sv */
// Datapath of the integrator: bounds, step, abscissa, sine sum, the split
// magnitude product, rounding, saturation and the result word registers.
// Depends on sqi_pkg, sqi_div and sqi_cordic.
module sqi_datapath
    import sqi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [METH_W-1:0]         cfg_data,
    input  logic signed [BOUND_W-1:0] lower_bound,
    input  logic signed [BOUND_W-1:0] upper_bound,
    input  logic [PART_W-1:0]         partitions,
    input  sqi_cmd_t                  cmd,
    output sqi_status_t               st,
    output logic signed [RES_W-1:0]   integral,
    output logic                      bad_count
);

    logic [METH_W-1:0]       method_reg;
    logic signed [ANG_W-1:0] a_reg, b_reg, h_reg, x_reg;
    logic [PART_W-1:0]       n_reg, nm1_reg, k_reg;
    logic                    dneg_reg, neg_reg;
    logic signed [ACC_W-1:0] s_reg;
    logic [SMAG_W-1:0]       smag_reg;
    logic [HMAG_W-1:0]       hmag_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [1:0]              shidx_reg;
    logic [MUL_W-1:0]        acc_reg;
    logic signed [RES_W-1:0] res_reg, out_int_reg;
    logic                    res_bad_reg, out_bad_reg;
    logic [D3_W-1:0]         d3_val_reg, d3_quo_reg;
    logic [1:0]              d3_rem_reg;
    logic [1:0]              d3_cnt_reg;

    logic signed [ANG_W-1:0] diff, diff_abs, h_abs, ang, hq;
    logic signed [ACC_W-1:0] s_abs;
    logic [PART_W-1:0]       n_in;
    logic [PA_W-1:0]         pa;
    logic [PB_W-1:0]         pb;
    logic [MUL_W-1:0]        prod_sh;
    logic [MAG_W:0]          rnd_sum;
    logic [MAG_W:0]          rnd_add;
    logic [D3_W-1:0]         rnd_dvd;
    logic [DIV_W-1:0]        div_dvd, div_quo;
    logic                    div_done, sin_done;
    logic signed [SIN_W-1:0] sine;
    logic [DIV_W-1:0]        r_clip;
    logic [D3_V_W-1:0]       d3_v, d3_r;
    logic [D3_P_W-1:0]       d3_prod;
    logic [D3_CHUNK-1:0]     d3_q;

    localparam logic [DIV_W-1:0] LIM_POS = (DIV_W'(1) << (RES_W - 1)) - DIV_W'(1);
    localparam logic [DIV_W-1:0] LIM_NEG = DIV_W'(1) << (RES_W - 1);

    always_comb
    begin
        n_in = (32'(partitions) > 32'(MAX_PARTITIONS)) ? PART_W'(MAX_PARTITIONS)
                                                      : partitions;
        diff     = b_reg - a_reg;
        diff_abs = diff[ANG_W-1] ? -diff : diff;
        h_abs    = h_reg[ANG_W-1] ? -h_reg : h_reg;
        s_abs    = s_reg[ACC_W-1] ? -s_reg : s_reg;
        hq       = $signed(div_quo[ANG_W-1:0]);

        case (cmd.angle_sel)
            PH_A:    ang = a_reg;
            PH_B:    ang = b_reg;
            PH_X:    ang = x_reg;
            PH_MID:  ang = x_reg + (h_reg >>> 1);
            PH_END:  ang = x_reg + h_reg;
            default: ang = x_reg;
        endcase

        case (cmd.mul_idx)
            2'd0:    begin pa = smag_reg[PA_W-1:0];      pb = hmag_reg[PB_W-1:0]; end
            2'd1:    begin pa = smag_reg[PA_W-1:0];
                           pb = PB_W'(hmag_reg[HMAG_W-1:PB_W]); end
            2'd2:    begin pa = smag_reg[SMAG_W-1:PA_W]; pb = hmag_reg[PB_W-1:0]; end
            default: begin pa = smag_reg[SMAG_W-1:PA_W];
                           pb = PB_W'(hmag_reg[HMAG_W-1:PB_W]); end
        endcase

        case (shidx_reg)
            2'd0:    prod_sh = MUL_W'(prod_reg);
            2'd1:    prod_sh = MUL_W'(prod_reg) << PB_W;
            2'd2:    prod_sh = MUL_W'(prod_reg) << PA_W;
            default: prod_sh = MUL_W'(prod_reg) << (PA_W + PB_W);
        endcase

        // Round half up on the magnitude; Simpson divides by 3 afterwards.
        case (method_reg)
            METH_RECT: rnd_add = (MAG_W + 1)'(128);
            METH_TRAP: rnd_add = (MAG_W + 1)'(256);
            default:   rnd_add = (MAG_W + 1)'(768);
        endcase
        rnd_sum = {1'b0, acc_reg[MUL_W-1:MAG_LSB]} + rnd_add;
        rnd_dvd = (method_reg == METH_RECT) ? D3_W'(rnd_sum >> 8) : D3_W'(rnd_sum >> 9);

        // One 18-bit digit of the division by three, carrying the remainder.
        d3_v    = {d3_rem_reg, d3_val_reg[D3_W-1:D3_W-D3_CHUNK]};
        d3_prod = D3_P_W'(d3_v) * D3_P_W'(D3_MUL);
        d3_q    = d3_prod[D3_SH+D3_CHUNK-1:D3_SH];
        d3_r    = d3_v - ({2'b00, d3_q} + {1'b0, d3_q, 1'b0});

        div_dvd = DIV_W'($unsigned(diff_abs));

        if (neg_reg)
            r_clip = (DIV_W'(d3_quo_reg) > LIM_NEG) ? LIM_NEG : DIV_W'(d3_quo_reg);
        else
            r_clip = (DIV_W'(d3_quo_reg) > LIM_POS) ? LIM_POS : DIV_W'(d3_quo_reg);

        st.n_zero   = (n_reg == '0);
        st.k_last   = (k_reg == nm1_reg);
        st.div_done = div_done;
        st.sin_done = sin_done;
        st.rnd_done = (d3_cnt_reg == '0);
        st.method   = method_reg;
    end

    sqi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    sqi_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sin_start),
        .angle (ang),
        .done  (sin_done),
        .sine  (sine)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            method_reg <= METH_RECT;
        else if (cfg_we)
            method_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d3_cnt_reg <= '0;
        else if (cmd.rnd_start)
            d3_cnt_reg <= (method_reg == METH_SIMP) ? 2'(D3_STEPS) : 2'd0;
        else if (d3_cnt_reg != '0)
            d3_cnt_reg <= d3_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg   <= {{ANG_EXT{lower_bound[BOUND_W-1]}}, lower_bound, ANG_PAD'(0)};
            b_reg   <= {{ANG_EXT{upper_bound[BOUND_W-1]}}, upper_bound, ANG_PAD'(0)};
            x_reg   <= {{ANG_EXT{lower_bound[BOUND_W-1]}}, lower_bound, ANG_PAD'(0)};
            n_reg   <= n_in;
            nm1_reg <= n_in - 1'b1;
            k_reg   <= '0;
            s_reg   <= '0;
        end
        else
        begin
            if (cmd.sin_add)
                s_reg <= s_reg + (ACC_W'(sine) <<< cmd.weight);
            if (cmd.x_step)
            begin
                x_reg <= x_reg + h_reg;
                k_reg <= k_reg + 1'b1;
            end
        end

        if (cmd.div_start)
            dneg_reg <= diff[ANG_W-1];
        if (cmd.h_take)
            h_reg <= dneg_reg ? -hq : hq;

        if (cmd.mul_prep)
        begin
            smag_reg <= s_abs[SMAG_W-1:0];
            hmag_reg <= h_abs[HMAG_W-1:0];
            neg_reg  <= s_reg[ACC_W-1] ^ h_reg[ANG_W-1];
            acc_reg  <= '0;
        end
        else if (cmd.mul_acc)
            acc_reg <= acc_reg + prod_sh;
        if (cmd.mul_en)
        begin
            prod_reg  <= pa * pb;
            shidx_reg <= cmd.mul_idx;
        end

        // Rectangle and trapezoid take the rounded value as it is; Simpson
        // shifts it through the divide-by-three digits, top digit first.
        if (cmd.rnd_start)
        begin
            d3_rem_reg <= '0;
            if (method_reg == METH_SIMP)
            begin
                d3_val_reg <= rnd_dvd;
                d3_quo_reg <= '0;
            end
            else
            begin
                d3_val_reg <= '0;
                d3_quo_reg <= rnd_dvd;
            end
        end
        else if (d3_cnt_reg != '0)
        begin
            d3_val_reg <= d3_val_reg << D3_CHUNK;
            d3_quo_reg <= {d3_quo_reg[D3_W-D3_CHUNK-1:0], d3_q};
            d3_rem_reg <= d3_r[1:0];
        end

        if (cmd.set_zero)
        begin
            res_reg     <= '0;
            res_bad_reg <= cmd.set_bad;
        end
        else if (cmd.res_take)
        begin
            res_reg     <= neg_reg ? -$signed(r_clip[RES_W-1:0]) : $signed(r_clip[RES_W-1:0]);
            res_bad_reg <= 1'b0;
        end

        if (cmd.out_load)
        begin
            out_int_reg <= res_reg;
            out_bad_reg <= res_bad_reg;
        end
    end

    assign integral  = out_int_reg;
    assign bad_count = out_bad_reg;

endmodule
